/* rtl/kpe_pkg.sv */
// Shared types and constants of the Kronecker product engine.
package kpe_pkg;

  localparam int ROW_W   = 6;
  localparam int COL_W   = 3;
  localparam int VAL_W   = 32;
  localparam int OCOL_W  = 6;
  localparam int DIM_W   = 5;
  localparam int REG_W   = 4;
  localparam int CNT_W   = 7;
  localparam int MAX_OUT = 64;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;

  localparam logic [1:0] KIND_WR_A = 2'd0;
  localparam logic [1:0] KIND_WR_B = 2'd1;
  localparam logic [1:0] KIND_EMIT = 2'd2;

  localparam logic [1:0] REG_A_ROWS = 2'd0;
  localparam logic [1:0] REG_A_COLS = 2'd1;
  localparam logic [1:0] REG_B_ROWS = 2'd2;
  localparam logic [1:0] REG_B_COLS = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_RUN  = 3'b100
  } kpe_state_e;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [OCOL_W-1:0] col;
    logic              last;
  } kpe_meta_t;

  // zero counts as one, anything above the maximum saturates
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [REG_W-1:0] v,
                                                  input logic [DIM_W-1:0] maxd);
    logic [DIM_W-1:0] r;
    r = {1'b0, v};
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (r > maxd) begin
      r = maxd;
    end
    return r;
  endfunction

endpackage

/* rtl/kpe_ram.sv */
// Generic simple dual-port RAM with registered, enabled read.
module kpe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/kronecker_product_engine.sv */
// Kronecker product engine: top level with matrix stores, row divider and product stream.
//
// An element write is accepted while idle and lands in the A or B store. An emit beat
// holds off the next input beat until its row is issued: the beat is accepted, then
// six steps of a bit-serial divider split the result row into its A and
// B rows, then one read of each store per cycle, so products leave at one per cycle
// as long as the output side keeps up. The rate is set by the single read port of each
// store. Products pass a registered multiply stage into the output register, and a new
// input beat may be taken while the last products of a row still wait to be taken.
module kronecker_product_engine #(
  parameter int MAX_A_DIM = 8,
  parameter int MAX_B_DIM = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input beat
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: row[5:0], col[8:6], value[40:9], zero pad
  input  logic [kpe_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // tuser: kind[1:0]
  input  logic [1:0]                          s_axis_tuser,
  // result beat
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata: out_row[5:0], out_col[11:6], product[43:12], zero pad
  output logic [kpe_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic                                m_axis_tlast,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [3:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  localparam int A_DEPTH = MAX_A_DIM * MAX_A_DIM;
  localparam int B_DEPTH = MAX_B_DIM * MAX_B_DIM;
  localparam int A_AW    = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
  localparam int B_AW    = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
  localparam int AIW     = (MAX_A_DIM > 1) ? $clog2(MAX_A_DIM) : 1;
  localparam int BIW     = (MAX_B_DIM > 1) ? $clog2(MAX_B_DIM) : 1;
  localparam int DW      = kpe_pkg::DIM_W;
  localparam int RW      = kpe_pkg::ROW_W;
  localparam int VW      = kpe_pkg::VAL_W;
  localparam int NW      = kpe_pkg::CNT_W;

  // configuration registers
  logic [kpe_pkg::REG_W-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;
  logic                      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_rows_q <= kpe_pkg::REG_W'(1);
      a_cols_q <= kpe_pkg::REG_W'(1);
      b_rows_q <= kpe_pkg::REG_W'(1);
      b_cols_q <= kpe_pkg::REG_W'(1);
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        kpe_pkg::REG_A_ROWS: a_rows_q <= pwdata[kpe_pkg::REG_W-1:0];
        kpe_pkg::REG_A_COLS: a_cols_q <= pwdata[kpe_pkg::REG_W-1:0];
        kpe_pkg::REG_B_ROWS: b_rows_q <= pwdata[kpe_pkg::REG_W-1:0];
        kpe_pkg::REG_B_COLS: b_cols_q <= pwdata[kpe_pkg::REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      kpe_pkg::REG_A_ROWS: prdata = {28'd0, a_rows_q};
      kpe_pkg::REG_A_COLS: prdata = {28'd0, a_cols_q};
      kpe_pkg::REG_B_ROWS: prdata = {28'd0, b_rows_q};
      kpe_pkg::REG_B_COLS: prdata = {28'd0, b_cols_q};
      default:             prdata = '0;
    endcase
  end

  // input fields
  logic [RW-1:0]            in_row;
  logic [kpe_pkg::COL_W-1:0] in_col;
  logic [VW-1:0]            in_val;
  logic                     in_acc;

  assign in_row = s_axis_tdata[5:0];
  assign in_col = s_axis_tdata[8:6];
  assign in_val = s_axis_tdata[40:9];

  // clamped dimensions
  logic [DW-1:0]   ar, ac, br, bc;
  logic [2*DW-1:0] nrows, ncols_full;

  assign ar = kpe_pkg::clamp_dim(a_rows_q, DW'(MAX_A_DIM));
  assign ac = kpe_pkg::clamp_dim(a_cols_q, DW'(MAX_A_DIM));
  assign br = kpe_pkg::clamp_dim(b_rows_q, DW'(MAX_B_DIM));
  assign bc = kpe_pkg::clamp_dim(b_cols_q, DW'(MAX_B_DIM));
  assign nrows      = ar * br;
  assign ncols_full = ac * bc;

  // store writes
  logic            a_we, b_we;
  logic [A_AW-1:0] a_waddr;
  logic [B_AW-1:0] b_waddr;

  assign a_we = in_acc && (s_axis_tuser == kpe_pkg::KIND_WR_A)
             && (32'(in_row) < MAX_A_DIM) && (32'(in_col) < MAX_A_DIM);
  assign b_we = in_acc && (s_axis_tuser == kpe_pkg::KIND_WR_B)
             && (32'(in_row) < MAX_B_DIM) && (32'(in_col) < MAX_B_DIM);
  assign a_waddr = A_AW'(32'(in_row) * MAX_A_DIM + 32'(in_col));
  assign b_waddr = B_AW'(32'(in_row) * MAX_B_DIM + 32'(in_col));

  // control
  kpe_pkg::kpe_state_e state_q, state_d;
  logic [RW-1:0]  row_q, dvd_q, quot_q, rem_q;
  logic [2:0]     cnt_q;
  logic [DW-1:0]  br_q, bc_q;
  logic [NW-1:0]  ncols_q, j_q;
  logic [AIW-1:0] ra_q, ja_q;
  logic [BIW-1:0] rb_q, jb_q;
  logic [RW-1:0]  trial, rem_d;
  logic           qbit, start, issue, last_issue;

  assign s_axis_tready = (state_q == kpe_pkg::ST_IDLE);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign start  = in_acc && (s_axis_tuser == kpe_pkg::KIND_EMIT)
               && ({4'd0, in_row} < nrows);

  assign trial = {rem_q[RW-2:0], dvd_q[RW-1]};
  assign qbit  = (trial >= RW'(br_q));
  assign rem_d = qbit ? (trial - RW'(br_q)) : trial;

  // pipeline: read stage then multiply into the output register
  logic               s1_valid_q, s1_adv, out_free;
  kpe_pkg::kpe_meta_t s1_meta_q, out_meta_q;
  logic [VW-1:0]      a_rdata, b_rdata, prod_q;
  logic               out_valid_q;
  logic [A_AW-1:0]    a_raddr;
  logic [B_AW-1:0]    b_raddr;

  assign out_free   = !out_valid_q || m_axis_tready;
  assign s1_adv     = s1_valid_q && out_free;
  assign issue      = (state_q == kpe_pkg::ST_RUN) && (!s1_valid_q || s1_adv);
  assign last_issue = (j_q + NW'(1) == ncols_q);
  assign a_raddr    = A_AW'(32'(ra_q) * MAX_A_DIM + 32'(ja_q));
  assign b_raddr    = B_AW'(32'(rb_q) * MAX_B_DIM + 32'(jb_q));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      kpe_pkg::ST_IDLE: if (start) state_d = kpe_pkg::ST_DIV;
      kpe_pkg::ST_DIV:  if (cnt_q == 3'(RW - 1)) state_d = kpe_pkg::ST_RUN;
      kpe_pkg::ST_RUN:  if (issue && last_issue) state_d = kpe_pkg::ST_IDLE;
      default:          state_d = kpe_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kpe_pkg::ST_IDLE;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (issue) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      row_q   <= in_row;
      dvd_q   <= in_row;
      rem_q   <= '0;
      quot_q  <= '0;
      cnt_q   <= '0;
      br_q    <= br;
      bc_q    <= bc;
      ncols_q <= (32'(ncols_full) > kpe_pkg::MAX_OUT) ? NW'(kpe_pkg::MAX_OUT)
                                                       : NW'(ncols_full);
    end
    if (state_q == kpe_pkg::ST_DIV) begin
      dvd_q  <= {dvd_q[RW-2:0], 1'b0};
      rem_q  <= rem_d;
      quot_q <= {quot_q[RW-2:0], qbit};
      cnt_q  <= cnt_q + 3'd1;
      ra_q   <= AIW'({quot_q[RW-2:0], qbit});
      rb_q   <= BIW'(rem_d);
      j_q    <= '0;
      ja_q   <= '0;
      jb_q   <= '0;
    end
    if (issue) begin
      s1_meta_q.row  <= row_q;
      s1_meta_q.col  <= j_q[kpe_pkg::OCOL_W-1:0];
      s1_meta_q.last <= last_issue;
      j_q <= j_q + NW'(1);
      if (DW'(jb_q) == bc_q - DW'(1)) begin
        jb_q <= '0;
        ja_q <= ja_q + AIW'(1);
      end else begin
        jb_q <= jb_q + BIW'(1);
      end
    end
    if (s1_adv) begin
      out_meta_q <= s1_meta_q;
      prod_q     <= a_rdata * b_rdata;
    end
  end

  kpe_ram #(.WIDTH(VW), .DEPTH(A_DEPTH)) u_a_store (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_waddr),
    .wdata_i (in_val),
    .re_i    (issue),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  kpe_ram #(.WIDTH(VW), .DEPTH(B_DEPTH)) u_b_store (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (in_val),
    .re_i    (issue),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_meta_q.last;
  assign m_axis_tdata  = {4'd0, prod_q, out_meta_q.col, out_meta_q.row};

  // reads only while streaming a row
  a_issue_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> state_q == kpe_pkg::ST_RUN)
    else $error("store read outside row streaming");

  // element writes never leave idle
  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser != kpe_pkg::KIND_EMIT) |=> state_q == kpe_pkg::ST_IDLE)
    else $error("write beat left idle");

  // a stalled read stage keeps its element
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_free) |=> s1_valid_q && $stable(s1_meta_q))
    else $error("read stage lost a stalled element");

  // divider never runs past its step count
  a_div_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == kpe_pkg::ST_DIV |-> cnt_q < 3'(RW))
    else $error("divider step count overrun");

  // issuing the final column of a row marks the row end and returns to idle
  a_last_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && last_issue) |=> s1_meta_q.last && state_q == kpe_pkg::ST_IDLE)
    else $error("row end not marked");

endmodule
